/* rtl/kde_pkg.sv */
package kde_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_EVAL   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;

  localparam logic CFG_INV_BANDWIDTH = 1'b0;
  localparam logic CFG_DENSITY_FLOOR = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [31:0] density;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_EVAL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] value;
  } req_t;

endpackage

/* rtl/gaussian_kde_1d_eval_unit.sv */
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_item (command, sample_value)
// out       out_valid / out_ready out_item (density, status)
// cfg       cfg_we                cfg_index, cfg_data
//
// Clear, append and unused requests are answered directly from the idle state.
// An evaluation sweeps the sample memory one entry per cycle through a
// four-stage kernel pipeline, then runs a bit-serial divider of CW + 33
// steps; a last state floors the density or saturates it.
// Reset empties the store; no clearing pass is needed.
// A two-entry queue lets requests arrive while an evaluation runs.
module gaussian_kde_1d_eval_unit #(
  parameter int MAX_SAMPLES        = 1024,
  parameter int KERNEL_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kde_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output kde_pkg::out_t out_item,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  logic [15:0]   inv_bandwidth;
  logic [31:0]   density_floor;
  logic          push_valid;
  logic          push_ready;
  kde_pkg::req_t push_req;
  logic          pop_valid;
  logic          pop_ready;
  kde_pkg::req_t pop_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_bandwidth <= 16'd256;
      density_floor <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        kde_pkg::CFG_INV_BANDWIDTH: inv_bandwidth <= cfg_data[15:0];
        kde_pkg::CFG_DENSITY_FLOOR: density_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  kde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  kde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  kde_back #(
    .MAX_SAMPLES        (MAX_SAMPLES),
    .KERNEL_TABLE_DEPTH (KERNEL_TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_req       (pop_req),
    .inv_bandwidth (inv_bandwidth),
    .density_floor (density_floor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == kde_pkg::STAT_EMPTY |-> out_item.density == 32'd0)
    else $error("empty store result carries a nonzero density");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == kde_pkg::STAT_FULL |-> out_item.density == 32'd0)
    else $error("dropped append carries a nonzero density");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == kde_pkg::STAT_SAT |-> out_item.density == 32'hFFFF_FFFF)
    else $error("saturated result is not at the maximum");

endmodule

/* rtl/kde_front.sv */
module kde_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  kde_pkg::in_t in_item,
  output logic         push_valid,
  input  logic         push_ready,
  output kde_pkg::req_t push_req
);

  logic          hold_valid;
  kde_pkg::req_t hold_req;
  kde_pkg::req_t req_next;

  always_comb begin
    req_next.value = in_item.sample_value;
    case (in_item.command)
      kde_pkg::CMD_CLEAR:  req_next.op = kde_pkg::OP_CLEAR;
      kde_pkg::CMD_APPEND: req_next.op = kde_pkg::OP_APPEND;
      kde_pkg::CMD_EVAL:   req_next.op = kde_pkg::OP_EVAL;
      default:             req_next.op = kde_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_req   = hold_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_req <= req_next;
    end
  end

endmodule

/* rtl/kde_queue.sv */
module kde_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  kde_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop_ready,
  output kde_pkg::req_t pop_req
);

  kde_pkg::req_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_req    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

/* rtl/kde_back.sv */
module kde_back #(
  parameter int MAX_SAMPLES        = 1024,
  parameter int KERNEL_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  kde_pkg::req_t pop_req,
  input  logic [15:0]   inv_bandwidth,
  input  logic [31:0]   density_floor,
  output logic          out_valid,
  input  logic          out_ready,
  output kde_pkg::out_t out_item
);

  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int KAW  = $clog2(KERNEL_TABLE_DEPTH);
  localparam int KDW  = $clog2(KERNEL_TABLE_DEPTH + 1);
  localparam int PW   = 32 + KDW + 1;
  localparam int IW   = PW - 19;
  localparam int SUMW = CW + 16;
  localparam int NW   = CW + 33;
  localparam int DW   = CW + 8;
  localparam int SW   = $clog2(NW + 1);

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
    logic [64:0] part;
    logic [63:0] quo;
    part = '0;
    quo  = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, dvs}) begin
        part   = part - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [KERNEL_TABLE_DEPTH*16-1:0] build_rom();
    logic [KERNEL_TABLE_DEPTH*16-1:0] rom;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] v;
    rom = '0;
    for (int k = 0; k < KERNEL_TABLE_DEPTH; k++) begin
      x = udiv64((64'(k) * 64'(k)) << 37,
                 64'(KERNEL_TABLE_DEPTH) * 64'(KERNEL_TABLE_DEPTH));
      n = x >> 32;
      f = x & 64'hFFFF_FFFF;
      term = 64'h1_0000_0000;
      pos = term;
      neg = 64'd0;
      for (int i = 1; i <= 20; i++) begin
        term = udiv64((term * f) >> 32, 64'(i));
        if ((i & 1) == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      r = (pos > neg) ? pos - neg : 64'd0;
      if (n > 64) begin
        r = 64'd0;
      end else begin
        for (int j = 0; j < 64; j++) begin
          if (64'(j) < n) begin
            r = (r * 64'd1580030169 + 64'h8000_0000) >> 32;
          end
        end
      end
      v = (r * 64'd1713444050 + 64'h8000_0000_0000) >> 48;
      rom[k*16 +: 16] = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    end
    return rom;
  endfunction

  localparam logic [KERNEL_TABLE_DEPTH*16-1:0] KROM = build_rom();

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t             state;
  logic [15:0]        mem [MAX_SAMPLES];
  logic [CW-1:0]      count;
  logic [CW-1:0]      issue_cnt;
  logic signed [16:0] point;
  logic [15:0]        rd_data;
  logic               v1;
  logic               v2;
  logic               v3;
  logic [31:0]        prod1;
  logic               in_range;
  logic [KAW-1:0]     kidx;
  logic [SUMW-1:0]    sum;
  logic [NW-1:0]      numq;
  logic [DW-1:0]      den;
  logic [DW-1:0]      rem;
  logic [SW-1:0]      step;

  logic               rd_en;
  logic               wr_en;
  logic               take;
  logic signed [16:0] diff;
  logic [15:0]        absd;
  logic [PW-1:0]      scaled;
  logic [IW-1:0]      idx_full;
  logic [DW:0]        rem_sh;
  logic               ge;

  assign pop_ready = (state == S_IDLE) && !out_valid;
  assign take      = pop_valid && pop_ready;
  assign rd_en     = (state == S_SWEEP) && (issue_cnt < count);
  assign wr_en     = take && (pop_req.op == kde_pkg::OP_APPEND) &&
                     (count < CW'(MAX_SAMPLES));

  always_comb begin
    diff     = point - 17'(signed'(rd_data));
    absd     = diff[16] ? 16'(-diff) : diff[15:0];
    scaled   = PW'(prod1) * PW'(KERNEL_TABLE_DEPTH) + PW'(1 << 18);
    idx_full = scaled[PW-1:19];
    rem_sh   = {rem, numq[NW-1]};
    ge       = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= pop_req.value;
    end
    if (rd_en) begin
      rd_data <= mem[issue_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            out_item.density <= '0;
            case (pop_req.op)
              kde_pkg::OP_CLEAR: begin
                count           <= '0;
                out_item.status <= kde_pkg::STAT_OK;
                out_valid       <= 1'b1;
              end
              kde_pkg::OP_APPEND: begin
                if (wr_en) begin
                  count           <= count + 1'b1;
                  out_item.status <= kde_pkg::STAT_OK;
                end else begin
                  out_item.status <= kde_pkg::STAT_FULL;
                end
                out_valid <= 1'b1;
              end
              kde_pkg::OP_EVAL: begin
                if (count == '0) begin
                  out_item.status <= kde_pkg::STAT_EMPTY;
                  out_valid       <= 1'b1;
                end else begin
                  point     <= 17'(pop_req.value);
                  issue_cnt <= '0;
                  sum       <= '0;
                  state     <= S_SWEEP;
                end
              end
              default: begin
                out_item.status <= kde_pkg::STAT_OK;
                out_valid       <= 1'b1;
              end
            endcase
          end
        end
        S_SWEEP: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (v1) begin
            prod1 <= 32'(absd) * 32'(inv_bandwidth);
          end
          if (v2) begin
            in_range <= idx_full < IW'(KERNEL_TABLE_DEPTH);
            kidx     <= idx_full[KAW-1:0];
          end
          if (v3 && in_range) begin
            sum <= sum + SUMW'(KROM[kidx*16 +: 16]);
          end
          if (!rd_en && !v1 && !v2 && !v3) begin
            numq  <= NW'(sum) * NW'(inv_bandwidth) + (NW'(count) << 7);
            den   <= DW'(count) << 8;
            rem   <= '0;
            step  <= '0;
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          rem  <= ge ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
          numq <= {numq[NW-2:0], ge};
          step <= step + 1'b1;
          if (step == SW'(NW - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (numq > NW'(32'hFFFF_FFFF)) begin
            out_item.density <= 32'hFFFF_FFFF;
            out_item.status  <= kde_pkg::STAT_SAT;
          end else if (numq[31:0] < density_floor) begin
            out_item.density <= density_floor;
            out_item.status  <= kde_pkg::STAT_OK;
          end else begin
            out_item.density <= numq[31:0];
            out_item.status  <= kde_pkg::STAT_OK;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
